### sv/swsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsr_pkg
// Shared types and constants for the single wire sensor reader.
// ----------------------------------------------------------------------------
package swsr_pkg;

  localparam int TimerWidthDefault = 16;

  // configuration register indexes
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;
  localparam logic [CfgIndexW-1:0] CFG_START_LOW = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_RESP_SKIP = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [CfgIndexW-1:0] CFG_TIMEOUT   = 2'd3;

  // reset values: 2 ms low, 200 us skip, 35 us threshold, 30 ms timeout
  localparam logic [15:0] START_LOW_RESET = 16'd2000;
  localparam logic [9:0]  RESP_SKIP_RESET = 10'd200;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd35;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd30000;

  // phase codes
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_START_LOW = 3'd1;
  localparam logic [2:0] PH_RESPONSE  = 3'd2;
  localparam logic [2:0] PH_WAIT_HIGH = 3'd3;
  localparam logic [2:0] PH_MEASURE   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;

  localparam logic [5:0] TOTAL_BITS = 6'd40;
  localparam logic [5:0] DATA_BITS  = 6'd32;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic [1:0]         status;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
  } result_t;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [9:0]  response_skip_ticks;
    logic [7:0]  bit_threshold_ticks;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

### sv/swsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsr_ctrl
// Configuration registers and the per-tick sequencer: start pulse, response
// skip, pulse timing, bit shifting, checksum and timeout.
// ----------------------------------------------------------------------------
module swsr_ctrl #(
  parameter int TIMER_WIDTH = swsr_pkg::TimerWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            start_request_i,
  input  logic                            line_level_i,
  input  logic                            cfg_we_i,
  input  logic [swsr_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [swsr_pkg::CfgDataW-1:0]   cfg_data_i,
  output swsr_pkg::result_t               result_o
);
  import swsr_pkg::*;

  localparam int TW = TIMER_WIDTH;
  localparam int CW = (TW > 16) ? TW : 16;

  cfg_t          cfg_q;
  logic [2:0]    phase_q, phase_d;
  logic [TW-1:0] elapsed_q, elapsed_d;
  logic [TW-1:0] mark_q, mark_d;
  logic [5:0]    bit_count_q, bit_count_d;
  logic [31:0]   data_q, data_d;
  logic [7:0]    csum_q, csum_d;
  logic [1:0]    status_q, status_d;
  logic          done;

  logic [TW-1:0] el_inc;
  logic [TW-1:0] span;
  logic          bit_val;
  logic [5:0]    cnt_inc;
  logic [7:0]    byte_sum;
  logic [14:0]   mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks     <= START_LOW_RESET;
      cfg_q.response_skip_ticks <= RESP_SKIP_RESET;
      cfg_q.bit_threshold_ticks <= THRESHOLD_RESET;
      cfg_q.timeout_ticks       <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_LOW: cfg_q.start_low_ticks     <= cfg_data_i;
        CFG_RESP_SKIP: cfg_q.response_skip_ticks <= cfg_data_i[9:0];
        CFG_THRESHOLD: cfg_q.bit_threshold_ticks <= cfg_data_i[7:0];
        CFG_TIMEOUT:   cfg_q.timeout_ticks       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // elapsed saturates at all ones
  assign el_inc   = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign span     = el_inc - mark_q;
  assign bit_val  = CW'(span) > CW'(cfg_q.bit_threshold_ticks);
  assign cnt_inc  = bit_count_q + 6'd1;
  assign byte_sum = data_q[7:0] + data_q[15:8] + data_q[23:16] + data_q[31:24];

  always_comb begin
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    mark_d      = mark_q;
    bit_count_d = bit_count_q;
    data_d      = data_q;
    csum_d      = csum_q;
    status_d    = status_q;
    done        = 1'b0;
    unique case (phase_q) inside
      PH_START_LOW, PH_RESPONSE, PH_WAIT_HIGH, PH_MEASURE: begin
        elapsed_d = el_inc;
        if (CW'(el_inc) > CW'(cfg_q.timeout_ticks) || (&el_inc)) begin
          phase_d  = PH_IDLE;
          status_d = ST_TIMEOUT;
          done     = 1'b1;
        end else if (phase_q == PH_START_LOW) begin
          if (CW'(el_inc) > CW'(cfg_q.start_low_ticks)) begin
            mark_d  = el_inc;
            phase_d = PH_RESPONSE;
          end
        end else if (phase_q == PH_RESPONSE) begin
          if (CW'(span) > CW'(cfg_q.response_skip_ticks) && !line_level_i) begin
            phase_d = PH_WAIT_HIGH;
          end
        end else if (phase_q == PH_WAIT_HIGH) begin
          if (line_level_i) begin
            mark_d  = el_inc;
            phase_d = PH_MEASURE;
          end
        end else if (!line_level_i) begin
          if (bit_count_q < DATA_BITS) begin
            data_d = {data_q[30:0], bit_val};
          end else begin
            csum_d = {csum_q[6:0], bit_val};
          end
          bit_count_d = cnt_inc;
          phase_d     = PH_WAIT_HIGH;
          // the last bit always lands in the checksum, so data_q is final
          if (cnt_inc >= TOTAL_BITS) begin
            phase_d  = PH_IDLE;
            status_d = (byte_sum == {csum_q[6:0], bit_val}) ? ST_OK : ST_CHECKSUM;
            done     = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (start_request_i) begin
          phase_d     = PH_START_LOW;
          elapsed_d   = '0;
          bit_count_d = '0;
          data_d      = '0;
          csum_d      = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      elapsed_q   <= '0;
      mark_q      <= '0;
      bit_count_q <= '0;
      data_q      <= '0;
      csum_q      <= '0;
      status_q    <= ST_OK;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      mark_q      <= mark_d;
      bit_count_q <= bit_count_d;
      data_q      <= data_d;
      csum_q      <= csum_d;
      status_q    <= status_d;
    end
  end

  // sign-magnitude to two's complement; negative zero gives zero
  assign mag = data_d[14:0];

  always_comb begin
    result_o.drive_low       = (phase_d == PH_START_LOW);
    result_o.busy_res        = (phase_d != PH_IDLE);
    result_o.done_res        = done;
    result_o.status          = status_d;
    result_o.humidity_tenths = data_d[31:16];
    result_o.temperature_tenths = data_d[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.done_res |-> !result_o.busy_res)
    else $error("done with read still busy");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_MEASURE && bit_count_q <= TOTAL_BITS)
    else $error("phase or bit count out of range");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_IDLE && start_request_i
    |=> phase_q == PH_START_LOW && elapsed_q == '0 && bit_count_q == '0)
    else $error("start request did not begin a read");

  a_drive_only_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.drive_low |-> phase_d == PH_START_LOW && result_o.busy_res)
    else $error("wire driven outside start phase");

endmodule

### sv/single_wire_sensor_reader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_unit
// Results: each accepted request's result is registered, in the skid entry if stalled.
// Throughput: one request per cycle while the skid entry is free; the sequencer step is a single pass.
// A two-entry output buffer keeps accepting while one result is stalled.
// Reset: async, active low; idle phase, status ok, data zero, config defaults.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader_unit #(
  parameter int TIMER_WIDTH = swsr_pkg::TimerWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           start_request_i,
  input  logic                           line_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           drive_low_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [1:0]                     status_o,
  output logic [15:0]                    humidity_tenths_o,
  output logic signed [15:0]             temperature_tenths_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [swsr_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [swsr_pkg::CfgDataW-1:0]  cfg_data_i
);
  import swsr_pkg::*;

  result_t res;
  result_t out_q, out_d, skid_q, skid_d;
  logic    outv_q, outv_d, skv_q, skv_d;
  logic    push, pop;

  assign in_ready_o  = !skv_q;
  assign cfg_ready_o = 1'b1;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = outv_q && out_ready_i;

  swsr_ctrl #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (push),
    .start_request_i(start_request_i),
    .line_level_i   (line_level_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_o       (res)
  );

  always_comb begin
    out_d  = out_q;
    outv_d = outv_q;
    skid_d = skid_q;
    skv_d  = skv_q;
    if (!outv_q || pop) begin
      if (skv_q) begin
        out_d  = skid_q;
        outv_d = 1'b1;
        skv_d  = push;
        skid_d = res;
      end else begin
        out_d  = res;
        outv_d = push;
      end
    end else if (push) begin
      skid_d = res;
      skv_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
      skv_q  <= 1'b0;
    end else begin
      outv_q <= outv_d;
      skv_q  <= skv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o          = outv_q;
  assign drive_low_o          = out_q.drive_low;
  assign busy_res_o           = out_q.busy_res;
  assign done_res_o           = out_q.done_res;
  assign status_o             = out_q.status;
  assign humidity_tenths_o    = out_q.humidity_tenths;
  assign temperature_tenths_o = out_q.temperature_tenths;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skv_q |-> outv_q)
    else $error("skid entry held with output empty");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !outv_q |=> outv_q)
    else $error("accepted request produced no result");

  a_stall_holds_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skv_q && !out_ready_i |=> skv_q && $stable(skid_q))
    else $error("stalled skid entry lost");

endmodule

### verif/single_wire_sensor_reader_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_unit_tb
// Drives microsecond ticks (start request, wire level) into the sensor reader
// and checks every per-tick readout against a cycle-exact model of the read
// sequence. It covers the register extremes and masking, timeouts while the
// line is held low and during the bit train, checksum errors and corrupted bit
// trains, with random input idles and output backpressure in most runs.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader_unit_tb;
  import swsr_pkg::*;

  class readout_checker;
    logic [15:0] start_low;
    logic [9:0]  resp_skip;
    logic [7:0]  threshold;
    logic [15:0] limit_ticks;

    logic [2:0]                   phase;
    logic [TimerWidthDefault-1:0] elapsed;
    logic [TimerWidthDefault-1:0] mark;
    logic [5:0]                   bits_in;
    logic [31:0]                  data_word;
    logic [7:0]                   sum_word;
    logic [1:0]                   status;

    result_t pending_readouts[$];
    int      mismatches;
    int      reports;
    int      finished[3];

    function new();
      start_low   = START_LOW_RESET;
      resp_skip   = RESP_SKIP_RESET;
      threshold   = THRESHOLD_RESET;
      limit_ticks = TIMEOUT_RESET;
      phase       = PH_IDLE;
      elapsed     = '0;
      mark        = '0;
      bits_in     = '0;
      data_word   = '0;
      sum_word    = '0;
      status      = ST_OK;
      mismatches  = 0;
      reports     = 0;
      finished    = '{0, 0, 0};
    endfunction

    function logic [7:0] byte_sum(logic [31:0] w);
      return w[7:0] + w[15:8] + w[23:16] + w[31:24];
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_START_LOW: start_low   = val;
        CFG_RESP_SKIP: resp_skip   = val[9:0];
        CFG_THRESHOLD: threshold   = val[7:0];
        CFG_TIMEOUT:   limit_ticks = val;
        default: ;
      endcase
    endfunction

    function bit reading_active();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return pending_readouts.size();
    endfunction

    // one tick of the read sequencer; queues the readout it produces
    function void predict_tick(logic start, logic level);
      result_t                      r;
      logic                         done;
      logic                         bitv;
      logic [TimerWidthDefault-1:0] span;
      logic [15:0]                  low_half;
      logic [15:0]                  mag;
      done = 1'b0;
      if (phase < PH_START_LOW || phase > PH_MEASURE) begin
        phase = PH_IDLE;
        if (start) begin
          phase     = PH_START_LOW;
          elapsed   = '0;
          bits_in   = '0;
          data_word = '0;
          sum_word  = '0;
        end
      end else begin
        if (elapsed != {TimerWidthDefault{1'b1}}) elapsed++;
        if (elapsed > limit_ticks || elapsed == {TimerWidthDefault{1'b1}}) begin
          phase  = PH_IDLE;
          status = ST_TIMEOUT;
          done   = 1'b1;
        end else begin
          case (phase)
            PH_START_LOW: begin
              if (elapsed > start_low) begin
                mark  = elapsed;
                phase = PH_RESPONSE;
              end
            end
            PH_RESPONSE: begin
              span = elapsed - mark;
              if (span > resp_skip && !level) phase = PH_WAIT_HIGH;
            end
            PH_WAIT_HIGH: begin
              if (level) begin
                mark  = elapsed;
                phase = PH_MEASURE;
              end
            end
            default: begin
              if (!level) begin
                span = elapsed - mark;
                bitv = span > threshold;
                if (bits_in < DATA_BITS) data_word = {data_word[30:0], bitv};
                else sum_word = {sum_word[6:0], bitv};
                bits_in++;
                phase = PH_WAIT_HIGH;
                if (bits_in >= TOTAL_BITS) begin
                  phase  = PH_IDLE;
                  status = (byte_sum(data_word) == sum_word) ? ST_OK : ST_CHECKSUM;
                  done   = 1'b1;
                end
              end
            end
          endcase
        end
      end
      if (done) finished[status]++;

      // low half is sign-magnitude; negative zero folds to 0
      low_half             = data_word[15:0];
      mag                  = {1'b0, low_half[14:0]};
      r.drive_low          = (phase == PH_START_LOW);
      r.busy_res           = (phase != PH_IDLE);
      r.done_res           = done;
      r.status             = status;
      r.humidity_tenths    = data_word[31:16];
      r.temperature_tenths = low_half[15] ? (16'd0 - mag) : mag;
      pending_readouts.push_back(r);
    endfunction

    function void note_mismatch(string field, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (reports < 100) begin
        reports++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_readout(result_t got);
      result_t want;
      if (pending_readouts.size() == 0) begin
        mismatches++;
        if (reports < 100) begin
          reports++;
          $display("%0t: readout with no request pending, expected none actual %h",
                   $time, got);
        end
        return;
      end
      want = pending_readouts.pop_front();
      if (got.drive_low !== want.drive_low)
        note_mismatch("drive_low", 16'(want.drive_low), 16'(got.drive_low));
      if (got.busy_res !== want.busy_res)
        note_mismatch("busy_res", 16'(want.busy_res), 16'(got.busy_res));
      if (got.done_res !== want.done_res)
        note_mismatch("done_res", 16'(want.done_res), 16'(got.done_res));
      if (got.status !== want.status)
        note_mismatch("status", 16'(want.status), 16'(got.status));
      if (got.humidity_tenths !== want.humidity_tenths)
        note_mismatch("humidity_tenths", want.humidity_tenths, got.humidity_tenths);
      if (got.temperature_tenths !== want.temperature_tenths)
        note_mismatch("temperature_tenths", want.temperature_tenths, got.temperature_tenths);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 start_request_i = 1'b0;
  logic                 line_level_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 drive_low_o;
  logic                 busy_res_o;
  logic                 done_res_o;
  logic [1:0]           status_o;
  logic [15:0]          humidity_tenths_o;
  logic signed [15:0]   temperature_tenths_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = CFG_START_LOW;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  readout_checker sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int reading_ticks  = 0;
  int readings       = 0;
  int cfg_writes     = 0;

  single_wire_sensor_reader_unit DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .start_request_i     (start_request_i),
    .line_level_i        (line_level_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .drive_low_o         (drive_low_o),
    .busy_res_o          (busy_res_o),
    .done_res_o          (done_res_o),
    .status_o            (status_o),
    .humidity_tenths_o   (humidity_tenths_o),
    .temperature_tenths_o(temperature_tenths_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_readout({drive_low_o, busy_res_o, done_res_o, status_o,
                        humidity_tenths_o, temperature_tenths_o});
  end

  // one tick request; returns at the edge where it is taken
  task automatic send_tick(input logic start, input logic level);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    start_request_i <= start;
    line_level_i    <= level;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_tick(start, level);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [15:0] v_start, input logic [15:0] v_skip,
                           input logic [15:0] v_thr, input logic [15:0] v_limit);
    logic [CfgIndexW-1:0] regs[4];
    logic [15:0]          vals[4];
    int                   r;
    regs = '{CFG_START_LOW, CFG_RESP_SKIP, CFG_THRESHOLD, CFG_TIMEOUT};
    vals = '{v_start, v_skip, v_thr, v_limit};
    for (r = 0; r < 4; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[r];
      cfg_data_i  <= vals[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(regs[r], vals[r]);
      cfg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Plays the sensor side of one read: start, line ignored while held low,
  // response window, then 40 high pulses whose width encodes each bit.
  // With breaks allowed the train may be cut short, get stray pulses, or
  // the line may stick high afterwards.
  task automatic run_reading(input logic [31:0] data, input logic [7:0] csum,
                             input bit allow_break);
    bit          levels[$];
    logic [39:0] frame;
    int          thr;
    int          h;
    int          i;
    int          nbits;
    int          pos;
    bit          stuck_high;
    bit          lv;
    frame      = {data, csum};
    thr        = int'(sb.threshold);
    nbits      = 40;
    stuck_high = 1'b0;
    if (allow_break && $urandom_range(0, 7) == 0) begin
      nbits      = $urandom_range(0, 39);
      stuck_high = 1'($urandom_range(0, 1));
    end

    repeat (int'(sb.start_low) + 1) levels.push_back(1'($urandom_range(0, 1)));
    repeat (int'(sb.resp_skip)) levels.push_back(1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 3)) levels.push_back(1'b1);
    levels.push_back(1'b0);
    for (i = 0; i < nbits; i++) begin
      repeat ($urandom_range(0, 2)) levels.push_back(1'b0);
      if (frame[39-i]) h = thr + 1 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2));
      else if (thr == 0) h = 1;
      else if ($urandom_range(0, (thr > 8) ? 19 : 3) == 0) h = thr;
      else h = $urandom_range(1, (thr < 3) ? thr : 3);
      repeat (h) levels.push_back(1'b1);
      levels.push_back(1'b0);
      if (allow_break && $urandom_range(0, 39) == 0) begin
        levels.push_back(1'b1);
        levels.push_back(1'b0);
      end
    end

    // ignored idle ticks between reads
    repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'($urandom_range(0, 1)));
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    readings++;
    reading_ticks++;
    pos = 0;
    // start requests while busy must be ignored
    while (sb.reading_active()) begin
      if (pos < levels.size()) lv = levels[pos];
      else lv = stuck_high ? 1'b1 : 1'($urandom_range(0, 1));
      pos++;
      send_tick($urandom_range(0, 3) == 0, lv);
      reading_ticks++;
    end
  endtask

  initial begin
    #10_000_000;
    $display("single_wire_sensor_reader_unit_tb: FAIL");
    $finish;
  end

  initial begin
    int          send_pcts[3];
    int          recv_pcts[3];
    int          mode;
    int          budget;
    logic [31:0] w;
    logic [7:0]  cs;
    send_pcts = '{17, 84, 0};
    recv_pcts = '{84, 17, 0};

    repeat (11) @(posedge clk_i);
    rst_ni         <= 1'b1;
    send_idle_pct  = send_pcts[0];
    recv_stall_pct = recv_pcts[0];

    // outputs before any read
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);

    settle();
    write_cfg(16'd1, 16'd0, 16'd1, 16'hFFFF);
    run_reading(32'hFFFF_8000, sb.byte_sum(32'hFFFF_8000), 1'b0);
    run_reading(32'h0000_FFFF, 8'h00, 1'b0);
    run_reading(32'h1234_7FFF, sb.byte_sum(32'h1234_7FFF), 1'b0);

    // upper data bits must be masked off: skip 3, threshold 2
    settle();
    write_cfg(16'd0, 16'hFC03, 16'hAB02, 16'hFFFF);
    run_reading(32'h0000_0001, 8'h01, 1'b0);

    // timeout while holding the line low, then a zero timeout
    settle();
    write_cfg(16'hFFFF, 16'd0, 16'd0, 16'd7);
    run_reading(32'h0, 8'h0, 1'b0);
    settle();
    write_cfg(16'd0, 16'd0, 16'd0, 16'd0);
    run_reading(32'h0, 8'h0, 1'b0);

    // zero threshold: every pulse is a one
    settle();
    write_cfg(16'd0, 16'd0, 16'd0, 16'hFFFF);
    run_reading(32'hFFFF_FFFF, 8'hFC, 1'b0);

    // timeout in the middle of the bit train
    settle();
    write_cfg(16'd2, 16'd3, 16'd2, 16'd60);
    run_reading(32'hA5C3_9E17, 8'h00, 1'b0);

    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct  = send_pcts[mode];
      recv_stall_pct = recv_pcts[mode];
      budget         = reading_ticks + 150;
      while (reading_ticks < budget) begin
        settle();
        write_cfg(16'($urandom_range(0, 8)),
                  16'($urandom_range(0, 8) |
                      (($urandom_range(0, 3) == 0) ? ($urandom & 32'hFC00) : 0)),
                  16'((($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4)) |
                      (($urandom_range(0, 3) == 0) ? ($urandom & 32'hFF00) : 0)),
                  16'($urandom_range(80, 500)));
        w = $urandom;
        case ($urandom_range(0, 5))
          0: w[15:0] = 16'h8000;
          1: w[15:0] = 16'hFFFF;
          2: w[15] = 1'b1;
          default: ;
        endcase
        cs = ($urandom_range(0, 4) == 0) ? 8'($urandom) : sb.byte_sum(w);
        run_reading(w, cs, 1'b1);
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d reads over %0d ticks: %0d ok, %0d checksum errors, %0d timeouts",
             readings, reading_ticks, sb.finished[ST_OK], sb.finished[ST_CHECKSUM],
             sb.finished[ST_TIMEOUT]);
    $display("%0d register writes, extremes and masked values included; %0d mismatches",
             cfg_writes, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("single_wire_sensor_reader_unit_tb: PASS");
    end else begin
      $display("single_wire_sensor_reader_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
